/* hw/rtl/substring_search_case_fold_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the case folding substring search
// Wrappers that clock and label concurrent assertions in one line each.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_SEARCH_CASE_FOLD_ASSERT_SVH
`define SUBSTRING_SEARCH_CASE_FOLD_ASSERT_SVH

// checked only while out of reset
`define SSF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define SSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/ssf_pkg.sv */
// ----------------------------------------------------------------------------
// ssf_pkg
// Types, constants and helpers shared by the substring search blocks.
// ----------------------------------------------------------------------------
package ssf_pkg;

    localparam int PATTERN_MAX   = 256;
    localparam int POSITION_BITS = 20;

    localparam int CHAR_W     = 8;
    localparam int SLOT_W     = 8;
    localparam int LEN_W      = 8;
    localparam int START_W    = 20;
    localparam int MPOS_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CNT_W = ((IDX_W + 1) > (LEN_W + 1)) ? (IDX_W + 1) : (LEN_W + 1);

    localparam int GROUP_W    = 16;
    localparam int NUM_GROUPS = (PATTERN_MAX + GROUP_W - 1) / GROUP_W;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_CASE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_UP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_INDEX    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [CHAR_W-1:0] char_code;
        logic [SLOT_W-1:0] pattern_slot;
        logic              end_of_text;
    } in_word_t;

    typedef struct packed {
        logic              found;
        logic [MPOS_W-1:0] match_position;
    } out_word_t;

    typedef struct packed {
        logic               match_case;
        logic               search_up;
        logic [START_W-1:0] start_index;
        logic [LEN_W-1:0]   pattern_length;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [CNT_W-1:0]  dest;
        logic [CHAR_W-1:0] code;
    } qwr_t;

    typedef struct packed {
        logic valid;
        logic last;
    } text_ctl_t;

    typedef enum logic {
        ST_RUN,
        ST_ALIGN
    } align_state_t;

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic exact);
        logic [CHAR_W-1:0] r;
        r = c;
        if (!exact && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/ssf_cell.sv */
// ----------------------------------------------------------------------------
// ssf_cell
// One window cell: a text byte, the aligned pattern byte and their compare.
// ----------------------------------------------------------------------------
module ssf_cell (
    input  logic                      aclk,
    input  logic                      shift_en,
    input  logic                      eq_en,
    input  logic                      match_case,
    input  logic                      in_use,
    input  logic                      q_we,
    input  logic [ssf_pkg::CHAR_W-1:0] q_code,
    input  logic [ssf_pkg::CHAR_W-1:0] char_in,
    output logic [ssf_pkg::CHAR_W-1:0] char_out,
    output logic                      eq_out
);
    import ssf_pkg::*;

    logic [CHAR_W-1:0] win_reg;
    logic [CHAR_W-1:0] pat_reg;
    logic              eq_reg;
    logic              eq_next;

    // char_in is the byte this cell holds once the shift happens
    always_comb begin
        eq_next = !in_use ||
                  (fold_char(char_in, match_case) == fold_char(pat_reg, match_case));
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            win_reg <= char_in;
        end
        if (q_we) begin
            pat_reg <= q_code;
        end
        if (eq_en) begin
            eq_reg <= eq_next;
        end
    end

    assign char_out = win_reg;
    assign eq_out   = eq_reg;

endmodule

/* hw/rtl/ssf_pat_store.sv */
// ----------------------------------------------------------------------------
// ssf_pat_store
// Pattern memory and realign pass that loads cell pattern bytes in reverse.
// ----------------------------------------------------------------------------
module ssf_pat_store (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       len_wr,
    input  logic [ssf_pkg::LEN_W-1:0]  pattern_length,
    input  logic                       load_en,
    input  logic [ssf_pkg::SLOT_W-1:0] load_slot,
    input  logic [ssf_pkg::CHAR_W-1:0] load_code,
    output logic                       busy,
    output ssf_pkg::qwr_t              qwr
);
    import ssf_pkg::*;

    align_state_t      state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CHAR_W-1:0] mem [PATTERN_MAX];
    logic [CHAR_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]  rd_k_reg;
    logic              rd_v_reg;
    logic              issue;
    logic              cnt_done;
    logic [CNT_W-1:0]  len_ext;
    logic [CNT_W-1:0]  slot_ext;

    assign len_ext  = CNT_W'(pattern_length);
    assign slot_ext = CNT_W'(load_slot);
    assign cnt_done = (cnt_reg == len_ext);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (len_wr) begin
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                if (len_wr) begin
                    state_next = ST_ALIGN;
                end else if (cnt_done) begin
                    state_next = ST_RUN;
                end
            end
        endcase
    end

    always_comb begin
        busy  = 1'b0;
        issue = 1'b0;
        unique case (state_reg)
            ST_RUN: begin
                busy = 1'b0;
            end
            ST_ALIGN: begin
                busy  = 1'b1;
                issue = !cnt_done;
            end
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (len_wr) begin
            cnt_next = '0;
        end else if (issue) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            cnt_reg   <= '0;
            rd_v_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rd_v_reg  <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en && slot_ext < CNT_W'(PATTERN_MAX)) begin
            mem[IDX_W'(load_slot)] <= load_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= mem[IDX_W'(cnt_reg)];
            rd_k_reg    <= cnt_reg;
        end
    end

    // pattern byte k sits in cell len-1-k, next to the window byte it meets
    always_comb begin
        qwr.en   = 1'b0;
        qwr.dest = len_ext - rd_k_reg - CNT_W'(1);
        qwr.code = rd_data_reg;
        priority if (rd_v_reg) begin
            qwr.en = 1'b1;
        end else if (load_en && slot_ext < len_ext) begin
            qwr.en   = 1'b1;
            qwr.dest = len_ext - slot_ext - CNT_W'(1);
            qwr.code = load_code;
        end
    end

endmodule

/* hw/rtl/ssf_match_track.sv */
// ----------------------------------------------------------------------------
// ssf_match_track
// Text position, compare reduction, best match tracking and result register.
// ----------------------------------------------------------------------------
module ssf_match_track (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ssf_pkg::text_ctl_t              text,
    input  ssf_pkg::cfg_t                   cfg,
    input  logic [ssf_pkg::PATTERN_MAX-1:0] eq_vec,
    input  logic                            m_ready,
    output logic                            adv,
    output logic                            m_valid,
    output ssf_pkg::out_word_t              m_data
);
    import ssf_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] taken, cand, len_pos;
    logic                     counted, len_ok;

    logic                     v1_reg, last1_reg, ok1_reg;
    logic [POSITION_BITS-1:0] cand1_reg;
    logic                     qual1;

    logic                     v2_reg, last2_reg, q2_reg;
    logic [POSITION_BITS-1:0] cand2_reg;
    logic [NUM_GROUPS*GROUP_W-1:0] eq_pad;
    logic [NUM_GROUPS-1:0]    grp_reg, grp_next;

    logic                     hit, stall, emit, pop;
    logic                     have_reg, have_next;
    logic [POSITION_BITS-1:0] best_reg, best_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     skid_valid_reg, skid_valid_next;
    logic                     head_load, skid_load;
    out_word_t                out_reg, out_next;
    out_word_t                skid_reg;

    // stage 0: position of the accepted byte
    assign len_pos = POSITION_BITS'(cfg.pattern_length);
    assign taken   = pos_reg + POSITION_BITS'(1);
    assign cand    = taken - len_pos;
    assign counted = (pos_reg != POS_MAX);
    assign len_ok  = (cfg.pattern_length != '0) &&
                     (CNT_W'(cfg.pattern_length) <= CNT_W'(PATTERN_MAX)) &&
                     (taken >= len_pos);

    always_comb begin
        pos_next = pos_reg;
        if (text.valid) begin
            if (text.last) begin
                pos_next = '0;
            end else if (counted) begin
                pos_next = taken;
            end
        end
    end

    // stage 1: start index window and compare groups
    always_comb begin
        if (cfg.search_up) begin
            qual1 = (64'(cand1_reg) <= 64'(cfg.start_index));
        end else begin
            qual1 = (64'(cand1_reg) >= 64'(cfg.start_index));
        end
    end

    always_comb begin
        eq_pad = '1;
        eq_pad[PATTERN_MAX-1:0] = eq_vec;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_next[g] = &eq_pad[g*GROUP_W +: GROUP_W];
        end
    end

    // stage 2: keep the match, hand out the word on the end mark
    assign pop   = out_valid_reg && m_ready;
    assign stall = v2_reg && last2_reg && skid_valid_reg;
    assign adv   = !stall;
    assign hit   = v2_reg && q2_reg && (&grp_reg);
    assign emit  = v2_reg && last2_reg && adv;

    always_comb begin
        have_next = have_reg;
        best_next = best_reg;
        if (hit) begin
            if (cfg.search_up) begin
                have_next = 1'b1;
                best_next = cand2_reg;
            end else if (!have_reg) begin
                have_next = 1'b1;
                best_next = cand2_reg;
            end
        end
        out_next.found          = have_next;
        out_next.match_position = have_next ? MPOS_W'(best_next) : '0;
    end

    // output register plus one spare, so a taken word frees room at once
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_load       = 1'b0;
        skid_load       = 1'b0;
        if (skid_valid_reg) begin
            if (pop) begin
                head_load       = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (emit) begin
            if (!out_valid_reg || pop) begin
                head_load      = 1'b1;
                out_valid_next = 1'b1;
            end else begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            have_reg       <= 1'b0;
            best_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (adv) begin
                v1_reg <= text.valid;
                v2_reg <= v1_reg;
                if (v2_reg) begin
                    if (last2_reg) begin
                        have_reg <= 1'b0;
                        best_reg <= '0;
                    end else begin
                        have_reg <= have_next;
                        best_reg <= best_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            last1_reg <= text.last;
            ok1_reg   <= counted && len_ok;
            cand1_reg <= cand;
            last2_reg <= last1_reg;
            q2_reg    <= ok1_reg && qual1;
            cand2_reg <= cand1_reg;
            grp_reg   <= grp_next;
        end
        if (head_load) begin
            out_reg <= skid_valid_reg ? skid_reg : out_next;
        end
        if (skid_load) begin
            skid_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* hw/rtl/substring_search_case_fold.sv */
// ----------------------------------------------------------------------------
// substring_search_case_fold
// Streaming substring search with optional ASCII case folding.
//
// Input words (s_): cmd 0 stores char_code at pattern_slot, cmd 1 pushes a
// text byte into a row of cells that each hold one window byte and the
// pattern byte aligned with it. The text word marked end_of_text yields one
// result word (m_) with found and match_position, then the search restarts.
// Registers are written via cfg_we/cfg_index/cfg_wdata, by the user only
// while idle; the block does not enforce it. Throughput is one word per
// cycle while s_ready is high; results pass the tracker's pipeline registers
// into the output register. Writing pattern_length starts a realign pass
// over the pattern memory, one byte per cycle, holding s_ready low. Reset
// clears the registers and search state; live_reg then raises s_ready.
// Results wait in an output register and one spare; s_ready also drops when
// a result arrives while both are held, until m_ready takes the oldest.
// ----------------------------------------------------------------------------
module substring_search_case_fold (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ssf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ssf_pkg::in_word_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ssf_pkg::out_word_t             m_data
);
    import ssf_pkg::*;

    cfg_t              cfg_reg;
    logic              live_reg;
    logic              busy, adv, accept, len_wr, load_en;
    text_ctl_t         text;
    qwr_t              qwr;
    logic [CHAR_W-1:0] chain [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] eq_vec, in_use, q_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg  <= '0;
            live_reg <= 1'b0;
        end else begin
            live_reg <= 1'b1;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_MATCH_CASE:     cfg_reg.match_case     <= cfg_wdata[0];
                    REG_SEARCH_UP:      cfg_reg.search_up      <= cfg_wdata[0];
                    REG_START_INDEX:    cfg_reg.start_index    <= cfg_wdata[START_W-1:0];
                    REG_PATTERN_LENGTH: cfg_reg.pattern_length <= cfg_wdata[LEN_W-1:0];
                endcase
            end
        end
    end

    assign len_wr     = cfg_we && (cfg_index == REG_PATTERN_LENGTH);
    assign s_ready    = live_reg && !busy && adv;
    assign accept     = s_valid && s_ready;
    assign load_en    = accept && (s_data.cmd == CMD_LOAD);
    assign text.valid = accept && (s_data.cmd == CMD_TEXT);
    assign text.last  = s_data.end_of_text;
    assign chain[0]   = s_data.char_code;

    ssf_pat_store u_store (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .len_wr         (len_wr),
        .pattern_length (cfg_reg.pattern_length),
        .load_en        (load_en),
        .load_slot      (s_data.pattern_slot),
        .load_code      (s_data.char_code),
        .busy           (busy),
        .qwr            (qwr)
    );

    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        assign in_use[j] = (CNT_W'(j) < CNT_W'(cfg_reg.pattern_length));
        assign q_hit[j]  = qwr.en && (qwr.dest == CNT_W'(j));
        if (j < PATTERN_MAX - 1) begin : g_mid
            ssf_cell u_cell (
                .aclk       (aclk),
                .shift_en   (text.valid),
                .eq_en      (adv),
                .match_case (cfg_reg.match_case),
                .in_use     (in_use[j]),
                .q_we       (q_hit[j]),
                .q_code     (qwr.code),
                .char_in    (chain[j]),
                .char_out   (chain[j+1]),
                .eq_out     (eq_vec[j])
            );
        end else begin : g_end
            ssf_cell u_cell (
                .aclk       (aclk),
                .shift_en   (text.valid),
                .eq_en      (adv),
                .match_case (cfg_reg.match_case),
                .in_use     (in_use[j]),
                .q_we       (q_hit[j]),
                .q_code     (qwr.code),
                .char_in    (chain[j]),
                .char_out   (),
                .eq_out     (eq_vec[j])
            );
        end
    end

    ssf_match_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .text    (text),
        .cfg     (cfg_reg),
        .eq_vec  (eq_vec),
        .m_ready (m_ready),
        .adv     (adv),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

/* hw/rtl/ssf_checker.sv */
// ----------------------------------------------------------------------------
// ssf_checker
// Port level checks of the substring search, bound to the top level.
// ----------------------------------------------------------------------------
`include "substring_search_case_fold_assert.svh"

module ssf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_we,
    input logic [ssf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [ssf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input logic                           s_valid,
    input logic                           s_ready,
    input ssf_pkg::in_word_t              s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input ssf_pkg::out_word_t             m_data
);
    import ssf_pkg::*;

    `SSF_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result word after reset")

    `SSF_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result word changed")

    `SSF_ASSERT(a_no_pos, aclk, aresetn, m_valid && !m_data.found |-> m_data.match_position == '0, "position without match")

    `SSF_ASSERT(a_realign, aclk, aresetn, cfg_we && cfg_index == REG_PATTERN_LENGTH |=> !s_ready, "ready during realign")

endmodule

bind substring_search_case_fold ssf_checker u_ssf_checker (.*);

/* bench/substring_search_case_fold_tb.sv */
// ----------------------------------------------------------------------------
// substring_search_case_fold_tb
// Self-checking bench for the streaming substring search. Pattern and text
// words are driven in random bursts; a scoreboard predicts each search result
// from its own copy of the pattern store, text window and registers and
// compares every result word field by field. Covers case folding, both search
// directions, start index extremes, long patterns and output back-pressure.
// ----------------------------------------------------------------------------
module substring_search_case_fold_tb;
    import ssf_pkg::*;

    localparam int unsigned POS_LIMIT   = (32'd1 << POSITION_BITS) - 1;
    localparam int unsigned START_MAX   = (32'd1 << START_W) - 1;
    localparam int unsigned LEN_MAX     = (32'd1 << LEN_W) - 1;
    localparam int unsigned SLOT_TOP    = 254;
    localparam int unsigned RANDOM_WORDS = 1600;
    localparam int unsigned IDLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam int unsigned MAX_LINES   = 50;

    class search_scoreboard;
        bit [CHAR_W-1:0] pattern_mem [PATTERN_MAX];
        bit [CHAR_W-1:0] window [PATTERN_MAX];
        int unsigned     head;
        int unsigned     text_pos;
        bit              have_match;
        int unsigned     best_pos;
        bit              exact;
        bit              search_up;
        int unsigned     start_index;
        int unsigned     pattern_length;
        out_word_t       result_q[$];
        int unsigned     errors;

        function new();
            restart_text();
        endfunction

        function void restart_text();
            foreach (window[i]) window[i] = '0;
            head = 0;
            text_pos = 0;
            have_match = 1'b0;
            best_pos = 0;
        endfunction

        function bit [CHAR_W-1:0] fold_byte(bit [CHAR_W-1:0] c);
            if (!exact && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return c + CASE_OFFSET;
            return c;
        endfunction

        // window[head] is the newest byte
        function bit pattern_ends_here(int unsigned len);
            int unsigned k;
            for (k = 0; k < len; k++) begin
                if (fold_byte(window[IDX_W'((head + len - 1 - k) % PATTERN_MAX)]) !=
                    fold_byte(pattern_mem[IDX_W'(k)])) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MATCH_CASE:     exact = data[0];
                REG_SEARCH_UP:      search_up = data[0];
                REG_START_INDEX:    start_index = 32'(data[START_W-1:0]);
                REG_PATTERN_LENGTH: pattern_length = 32'(data[LEN_W-1:0]);
                default: ;
            endcase
        endfunction

        function void note_word(in_word_t w);
            int unsigned taken;
            int unsigned match_start;
            out_word_t   res;
            if (w.cmd == CMD_LOAD) begin
                if (w.pattern_slot < PATTERN_MAX) pattern_mem[w.pattern_slot] = w.char_code;
                return;
            end
            head = (head + PATTERN_MAX - 1) % PATTERN_MAX;
            window[IDX_W'(head)] = w.char_code;
            if (text_pos < POS_LIMIT) begin
                taken = text_pos + 1;
                if (pattern_length != 0 && pattern_length <= PATTERN_MAX &&
                    taken >= pattern_length && pattern_ends_here(pattern_length)) begin
                    match_start = taken - pattern_length;
                    if (search_up) begin
                        if (match_start <= start_index) begin
                            have_match = 1'b1;
                            best_pos = match_start;
                        end
                    end else if (!have_match && match_start >= start_index) begin
                        have_match = 1'b1;
                        best_pos = match_start;
                    end
                end
                text_pos = taken;
            end
            if (w.end_of_text) begin
                res.found = have_match;
                res.match_position = have_match ? best_pos[MPOS_W-1:0] : '0;
                result_q.push_back(res);
                restart_text();
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_LINES) $display("MISMATCH: %s", msg);
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (result_q.size() == 0) begin
                report($sformatf("result with none pending: found=%0d pos=%0d",
                                 got.found, got.match_position));
                return;
            end
            want = result_q.pop_front();
            if (got.found !== want.found)
                report($sformatf("found %0d, predicted %0d", got.found, want.found));
            if (got.match_position !== want.match_position)
                report($sformatf("match_position %0d, predicted %0d",
                                 got.match_position, want.match_position));
        endfunction

        function int unsigned pending();
            return result_q.size();
        endfunction

        function void finish_check();
            if (result_q.size() != 0)
                report($sformatf("%0d results never arrived", result_q.size()));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_word_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_word_t             m_data;

    search_scoreboard sb = new();

    bit              hold_req    = 1'b0;
    bit              gaps_off    = 1'b0;
    int unsigned     burst_left  = 0;
    int unsigned     words_sent  = 0;
    int unsigned     cycle_count = 0;
    bit              slot_written [PATTERN_MAX];
    bit [CHAR_W-1:0] pattern_q[$];
    bit [CHAR_W-1:0] text_q[$];

    substring_search_case_fold DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) sb.check_result(m_data);
    end

    // result side: stretches of always-ready, sparse, periodic and heavy stalls, or a long hold on request
    initial begin
        int unsigned n, k, mode;
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                n = $urandom_range(5, 60);
                for (k = 0; k < n && !hold_req; k++) begin
                    case (mode)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= ($urandom_range(0, 3) != 0);
                        2:       m_ready <= (k % 3 == 0);
                        default: m_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    task automatic send_word(input in_word_t w);
        int unsigned gap;
        if (!gaps_off) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 12);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic send_load(input int unsigned slot, input bit [CHAR_W-1:0] c, input bit eot);
        in_word_t w;
        w.cmd = CMD_LOAD;
        w.char_code = c;
        w.pattern_slot = slot[SLOT_W-1:0];
        w.end_of_text = eot;
        slot_written[IDX_W'(slot)] = 1'b1;
        send_word(w);
    endtask

    task automatic send_text_byte(input bit [CHAR_W-1:0] c, input bit eot);
        in_word_t w;
        w.cmd = CMD_TEXT;
        w.char_code = c;
        w.pattern_slot = SLOT_W'($urandom_range(0, SLOT_TOP));
        w.end_of_text = eot;
        send_word(w);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // pattern_length last: its write starts the realign pass
    task automatic set_config(input bit mc, input bit up, input int unsigned start_pos,
                              input int unsigned len);
        put_reg(REG_MATCH_CASE, CFG_DATA_W'(mc));
        put_reg(REG_SEARCH_UP, CFG_DATA_W'(up));
        put_reg(REG_START_INDEX, CFG_DATA_W'(start_pos));
        put_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
        cfg_we <= 1'b0;
    endtask

    function automatic bit [CHAR_W-1:0] random_char();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4) return CHAR_W'(8'h61 + $urandom_range(0, 25));
        if (r < 7) return CHAR_W'(8'h41 + $urandom_range(0, 25));
        if (r == 7) begin
            case ($urandom_range(0, 3))
                0:       return 8'h40;
                1:       return 8'h5B;
                2:       return 8'h60;
                default: return 8'h7B;
            endcase
        end
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic bit [CHAR_W-1:0] swap_case(bit [CHAR_W-1:0] c);
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) return c ^ 8'h20;
        return c;
    endfunction

    function automatic bit [CHAR_W-1:0] maybe_swap(bit [CHAR_W-1:0] c);
        return $urandom_range(0, 1) ? swap_case(c) : c;
    endfunction

    function automatic bit all_written(int unsigned len);
        int unsigned k;
        for (k = 0; k < len; k++) if (!slot_written[IDX_W'(k)]) return 1'b0;
        return 1'b1;
    endfunction

    // text of whole, broken and cut copies of the pattern between filler runs
    function automatic void build_text();
        int unsigned segs, s, n, k, kind, cut;
        text_q.delete();
        segs = $urandom_range(1, 4);
        for (s = 0; s < segs; s++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4 && pattern_q.size() != 0) begin
                foreach (pattern_q[i]) text_q.push_back(maybe_swap(pattern_q[i]));
            end else if (kind < 6 && pattern_q.size() != 0) begin
                cut = $urandom_range(0, pattern_q.size() - 1);
                foreach (pattern_q[i]) begin
                    if (kind == 4 && i == cut) text_q.push_back(random_char());
                    else if (kind == 5 && i >= cut) break;
                    else text_q.push_back(maybe_swap(pattern_q[i]));
                end
            end else begin
                n = $urandom_range(0, 6);
                for (k = 0; k < n; k++) begin
                    if (pattern_q.size() != 0 && $urandom_range(0, 1))
                        text_q.push_back(maybe_swap(pattern_q[$urandom_range(0,
                                                               pattern_q.size() - 1)]));
                    else
                        text_q.push_back(random_char());
                end
            end
        end
        if (text_q.size() == 0) text_q.push_back(random_char());
    endfunction

    task automatic run_directed();
        send_load(0, 8'h41, 1'b0);
        send_load(1, 8'h00, 1'b0);
        send_load(2, 8'h7A, 1'b1);          // end mark on a load: no result
        send_load(SLOT_TOP, 8'hFF, 1'b0);
        wait_idle();
        set_config(1'b0, 1'b0, 0, 3);
        send_text_byte(8'h61, 1'b0);        // folded match at 0
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'h5A, 1'b1);
        send_text_byte(8'h00, 1'b0);        // match would begin before the text
        send_text_byte(8'h5A, 1'b1);
        send_text_byte(8'h40, 1'b0);        // '@' must not fold
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'h7A, 1'b0);
        send_text_byte(8'hFF, 1'b1);
        wait_idle();
        set_config(1'b1, 1'b1, START_MAX, 3);
        send_text_byte(8'h61, 1'b0);        // exact: only the second copy matches
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'h7A, 1'b0);
        send_text_byte(8'h41, 1'b0);
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'h7A, 1'b1);
        wait_idle();
        set_config(1'b0, 1'b0, 0, 0);       // empty pattern
        send_text_byte(8'h41, 1'b1);
    endtask

    task automatic run_phase(input int unsigned phase_no);
        int unsigned len, start_pos, texts, t, k;
        bit          mc, up, config_first;
        if (phase_no == 2) len = LEN_MAX;
        else if (phase_no == 6) len = $urandom_range(100, LEN_MAX - 1);
        else begin
            case ($urandom_range(0, 11))
                0:       len = 0;
                1:       len = $urandom_range(6, 40);
                default: len = $urandom_range(1, 5);
            endcase
        end
        pattern_q.delete();
        for (k = 0; k < len; k++) pattern_q.push_back(random_char());
        mc = 1'($urandom_range(0, 1));
        up = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0:       start_pos = 0;
            1:       start_pos = START_MAX;
            2:       start_pos = $urandom_range(0, START_MAX);
            default: start_pos = $urandom_range(0, 24);
        endcase
        config_first = all_written(len) && $urandom_range(0, 1);
        wait_idle();
        if (config_first) set_config(mc, up, start_pos, len);
        for (k = 0; k < len; k++) send_load(k, pattern_q[k], $urandom_range(0, 7) == 0);
        if (!config_first) begin
            wait_idle();
            set_config(mc, up, start_pos, len);
        end
        texts = $urandom_range(1, 4);
        for (t = 0; t < texts; t++) begin
            build_text();
            foreach (text_q[i]) begin
                if ($urandom_range(0, 29) == 0)
                    send_load($urandom_range(0, SLOT_TOP), random_char(),
                              1'($urandom_range(0, 1)));
                send_text_byte(text_q[i], i == text_q.size() - 1);
            end
        end
    endtask

    // results pile up behind a stalled output until the input stalls too
    task automatic run_backpressure();
        int unsigned t, n, k;
        wait_idle();
        hold_req = 1'b1;
        gaps_off = 1'b1;
        for (t = 0; t < 40; t++) begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) send_text_byte(random_char(), k == n - 1);
        end
        gaps_off = 1'b0;
        wait_idle();
    endtask

    initial begin
        int unsigned phase_no;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        words_sent = 0;
        phase_no = 0;
        while (words_sent < RANDOM_WORDS) begin
            run_phase(phase_no);
            if (phase_no == 0) run_backpressure();
            phase_no++;
        end
        wait_idle();
        sb.finish_check();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ssf_pkg.sv
hw/rtl/ssf_cell.sv
hw/rtl/ssf_pat_store.sv
hw/rtl/ssf_match_track.sv
hw/rtl/substring_search_case_fold.sv
hw/rtl/ssf_checker.sv
bench/substring_search_case_fold_tb.sv
